// File: hdl/tds_pkg.sv
// ---------------------------------------------------------------------------
// tds_pkg: shared constants for the timer divider search
// field widths, stream packing and fixed limits of the search
// ---------------------------------------------------------------------------
package tds_pkg;

	localparam int unsigned WORD_W     = 32;
	localparam int unsigned PSC_W      = 16;
	localparam int unsigned FACTOR_W   = 16;
	localparam int unsigned DIV_CNT_W  = 5;

	localparam int unsigned S_DATA_W   = 48;
	localparam int unsigned M_DATA_W   = 80;

	localparam logic [WORD_W-1:0] CLOCK_HZ_RESET    = 32'd84000000;
	localparam logic [WORD_W-1:0] RELOAD_LIM_NARROW = 32'h0001_0000;
	localparam logic [WORD_W-1:0] ERR_INIT          = 32'hFFFF_FFFF;

endpackage

// File: hdl/timer_divider_search.sv
// ---------------------------------------------------------------------------
// timer_divider_search: prescaler and auto-reload search
// tries each prescaler in turn and keeps the pair closest to the target rate
// ---------------------------------------------------------------------------
// first a division gives the divisor; then per prescaler tried a division for
// the reload, a multiply, a division for the achieved rate, compare and step,
// plus a division for a divisibility check; a reload out of range skips
// to the step. a final step loads the result. up to 65536 prescalers are tried.
// one bit-serial divider is shared by every division; one item at a time.
// arst_n clears the sequencer and output valid and loads clock_hz to 84 MHz.
module timer_divider_search
	import tds_pkg::*;
#(
	parameter int unsigned PRESCALER_MAX = 65535
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [WORD_W-1:0]   cfg_wdata,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,   // target_hz, divisibility_factor
	input  logic                s_tuser,   // narrow_reload
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,   // prescaler, reload, achieved_hz
	output logic                m_tuser    // found
);

	localparam logic [PSC_W-1:0]  PSC_MAX   = PSC_W'(PRESCALER_MAX);
	localparam logic [WORD_W-1:0] PSC_MAX_W = WORD_W'(PRESCALER_MAX);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL,
		ST_CHECK,
		ST_NEXT,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		PH_DIVISOR,
		PH_RELOAD,
		PH_FREQ,
		PH_MOD
	} phase_t;

	state_t state_q;
	phase_t phase_q;

	logic [WORD_W-1:0]    clock_q;
	logic [WORD_W-1:0]    target_q;
	logic [FACTOR_W-1:0]  factor_q;
	logic                 narrow_q;
	logic [WORD_W-1:0]    div_q;
	logic [PSC_W-1:0]     p_q;
	logic [PSC_W-1:0]     hi_q;
	logic [WORD_W-1:0]    r_q;
	logic [WORD_W-1:0]    freq_q;
	logic [WORD_W-1:0]    min_err_q;
	logic [PSC_W-1:0]     best_psc_q;
	logic [WORD_W-1:0]    best_rel_q;
	logic [WORD_W-1:0]    best_freq_q;
	logic                 found_q;

	// shared divider
	logic [WORD_W-1:0]    rem_q;
	logic [WORD_W-1:0]    quo_q;
	logic [WORD_W-1:0]    dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;

	logic [WORD_W:0]      trial;
	logic [WORD_W:0]      diff;
	logic                 ge;
	logic [WORD_W-1:0]    rem_nxt;
	logic [WORD_W-1:0]    quo_nxt;

	logic [WORD_W-1:0]    prod;
	logic [WORD_W-1:0]    p_plus1;
	logic [WORD_W-1:0]    err;
	logic [PSC_W-1:0]     lo_nxt;
	logic [PSC_W-1:0]     hi_nxt;
	logic                 s_xfer;

	logic [WORD_W-1:0]    o_rel_q;
	logic [WORD_W-1:0]    o_freq_q;
	logic [PSC_W-1:0]     o_psc_q;
	logic                 o_found_q;
	logic                 m_valid_q;

	assign s_tready = (state_q == ST_IDLE);
	assign s_xfer   = s_tvalid && s_tready;

	assign trial   = {rem_q, quo_q[WORD_W-1]};
	assign diff    = trial - {1'b0, dvs_q};
	assign ge      = !diff[WORD_W];
	assign rem_nxt = ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
	assign quo_nxt = {quo_q[WORD_W-2:0], ge};

	assign p_plus1 = WORD_W'(p_q) + WORD_W'(1);
	// (p+1)*r never exceeds the divisor, so 32 bits hold it
	assign prod    = WORD_W'(p_plus1 * r_q);
	assign err     = (freq_q > target_q) ? freq_q - target_q : target_q - freq_q;

	// search bounds from the divisor just produced
	always_comb begin
		lo_nxt = '0;
		if (narrow_q && quo_nxt > RELOAD_LIM_NARROW) begin
			lo_nxt = PSC_W'((quo_nxt - WORD_W'(1)) >> PSC_W);
		end
		hi_nxt = (quo_nxt < PSC_MAX_W) ? quo_nxt[PSC_W-1:0] : PSC_MAX;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			phase_q   <= PH_DIVISOR;
			clock_q   <= CLOCK_HZ_RESET;
			m_valid_q <= 1'b0;
			cnt_q     <= '0;
		end else begin
			if (cfg_we) begin
				clock_q <= cfg_wdata;
			end
			// in ST_FINISH the output register is handled below
			if (m_valid_q && m_tready && state_q != ST_FINISH) begin
				m_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_xfer) begin
						target_q    <= s_tdata[WORD_W-1:0];
						factor_q    <= s_tdata[WORD_W +: FACTOR_W];
						narrow_q    <= s_tuser;
						min_err_q   <= ERR_INIT;
						best_psc_q  <= '0;
						best_rel_q  <= '0;
						best_freq_q <= '0;
						found_q     <= 1'b0;
						if (s_tdata[WORD_W-1:0] == '0) begin
							state_q <= ST_FINISH;
						end else begin
							rem_q   <= '0;
							quo_q   <= clock_q;
							dvs_q   <= s_tdata[WORD_W-1:0];
							cnt_q   <= '0;
							phase_q <= PH_DIVISOR;
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + DIV_CNT_W'(1);
					if (cnt_q != '1) begin
						rem_q <= rem_nxt;
						quo_q <= quo_nxt;
					end else begin
						unique case (phase_q)
							PH_DIVISOR: begin
								div_q <= quo_nxt;
								hi_q  <= hi_nxt;
								p_q   <= lo_nxt;
								if (quo_nxt == '0 || lo_nxt > hi_nxt) begin
									state_q <= ST_FINISH;
								end else begin
									rem_q   <= '0;
									quo_q   <= quo_nxt;
									dvs_q   <= WORD_W'(lo_nxt) + WORD_W'(1);
									phase_q <= PH_RELOAD;
								end
							end
							PH_RELOAD: begin
								r_q <= quo_nxt;
								if (quo_nxt == '0 ||
								    (narrow_q && quo_nxt > RELOAD_LIM_NARROW)) begin
									state_q <= ST_NEXT;
								end else begin
									state_q <= ST_MUL;
								end
							end
							PH_FREQ: begin
								freq_q <= quo_nxt;
								if (factor_q > FACTOR_W'(1)) begin
									rem_q   <= '0;
									quo_q   <= quo_nxt;
									dvs_q   <= WORD_W'(factor_q);
									phase_q <= PH_MOD;
								end else begin
									state_q <= ST_CHECK;
								end
							end
							PH_MOD: begin
								state_q <= (rem_nxt != '0) ? ST_NEXT : ST_CHECK;
							end
							default: begin
								state_q <= ST_FINISH;
							end
						endcase
					end
				end
				ST_MUL: begin
					rem_q   <= '0;
					quo_q   <= clock_q;
					dvs_q   <= prod;
					cnt_q   <= '0;
					phase_q <= PH_FREQ;
					state_q <= ST_DIV;
				end
				ST_CHECK: begin
					if (err < min_err_q) begin
						min_err_q   <= err;
						best_psc_q  <= p_q;
						best_rel_q  <= r_q - WORD_W'(1);
						best_freq_q <= freq_q;
						found_q     <= 1'b1;
					end
					// exact match ends the search
					if (err == '0) begin
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_NEXT;
					end
				end
				ST_NEXT: begin
					if (p_q == hi_q) begin
						state_q <= ST_FINISH;
					end else begin
						p_q     <= p_q + PSC_W'(1);
						rem_q   <= '0;
						quo_q   <= div_q;
						dvs_q   <= p_plus1 + WORD_W'(1);
						cnt_q   <= '0;
						phase_q <= PH_RELOAD;
						state_q <= ST_DIV;
					end
				end
				ST_FINISH: begin
					// wait for the output register to be free
					if (!m_valid_q || m_tready) begin
						o_psc_q   <= best_psc_q;
						o_rel_q   <= best_rel_q;
						o_freq_q  <= best_freq_q;
						o_found_q <= found_q;
						m_valid_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {o_freq_q, o_rel_q, o_psc_q};
	assign m_tuser  = o_found_q;

endmodule
